/* design/cbe_pkg.sv */
// shared types and constants of the cubic bezier easing solver
`default_nettype none
package cbe_pkg;
  localparam int FRAC_BITS = 16;
  localparam int XW        = 17;
  localparam int YW        = 19;
  localparam int ACC_W     = 28;
  localparam int NUM_W     = ACC_W + FRAC_BITS;
  localparam int DEN_W     = ACC_W;
  localparam logic [XW-1:0] ONE_Q = XW'(1) << FRAC_BITS;

  localparam logic [2:0] CFG_CTRL1_X   = 3'd0;
  localparam logic [2:0] CFG_CTRL1_Y   = 3'd1;
  localparam logic [2:0] CFG_CTRL2_X   = 3'd2;
  localparam logic [2:0] CFG_CTRL2_Y   = 3'd3;
  localparam logic [2:0] CFG_TOLERANCE = 3'd4;

  typedef struct packed {
    logic                    en;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [ACC_W-1:0] add;
  } mac_req_t;
endpackage
`default_nettype wire

/* design/cbe_mac.sv */
// shared multiply-accumulate step: acc = floor(a * t) + add
`default_nettype none
module cbe_mac (
  input  wire logic                                 clk,
  input  wire cbe_pkg::mac_req_t                    req,
  input  wire logic [cbe_pkg::XW-1:0]               t_in,
  output logic signed [cbe_pkg::ACC_W-1:0]          acc
);
  logic signed [cbe_pkg::ACC_W+cbe_pkg::XW:0] prod;
  logic signed [cbe_pkg::ACC_W-1:0]           acc_r;
  logic signed [cbe_pkg::ACC_W-1:0]           acc_nxt;

  // product with floor, an arithmetic shift
  assign prod    = req.mul_a * $signed({1'b0, t_in});
  assign acc_nxt = $signed(prod[cbe_pkg::ACC_W+cbe_pkg::FRAC_BITS-1:cbe_pkg::FRAC_BITS])
                   + req.add;

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

/* design/cbe_div.sv */
// restoring divider on magnitudes, one quotient bit a cycle
`default_nettype none
module cbe_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [cbe_pkg::NUM_W-1:0]    num_mag,
  input  wire logic [cbe_pkg::DEN_W-1:0]    den_mag,
  output logic                              done,
  output logic                              running,
  output logic [cbe_pkg::NUM_W-1:0]         quo
);
  localparam int CW = $clog2(cbe_pkg::NUM_W + 1);

  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [cbe_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [cbe_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [cbe_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [cbe_pkg::DEN_W:0]     rem_sh;
  logic [cbe_pkg::DEN_W:0]     rem_sub;

  assign rem_sh  = {rem_r, quo_r[cbe_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // iteration control
  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      cnt_nxt = CW'(cbe_pkg::NUM_W);
      run_nxt = 1'b1;
      rem_nxt = '0;
      den_nxt = den_mag;
      quo_nxt = num_mag;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[cbe_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[cbe_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[cbe_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[cbe_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done    = done_r;
  assign running = run_r;
  assign quo     = quo_r;
endmodule
`default_nettype wire

/* design/cubic_bezier_ease_solver_unit.sv */
// top level: registers, solve sequencer and result word of the easing solver
//
// One word at a time: start is taken while busy is low, and busy stays high until
// the result word has been shown on out_valid for its single cycle; the receiver
// cannot stall, so that cycle is final. Each Newton step evaluates the curve and checks it,
// then takes the derivative and checks it, then runs the shared divider, one quotient
// bit a cycle; after the Newton steps come the bisection setup, the bisection steps,
// each an evaluation and a check, the output evaluation and the result word.
// All curve evaluations go through one multiply-accumulate unit in Horner form.
// Configuration must be written only while busy is low, a rule the block leaves to the user; cfg_ready is always high.
`default_nettype none
module cubic_bezier_ease_solver_unit #(
  parameter int NEWTON_STEPS = 8,
  parameter int BISECT_STEPS = 17
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [cbe_pkg::XW-1:0]             in_progress,
  output logic                                    out_valid,
  output logic signed [cbe_pkg::YW-1:0]           out_eased_value,
  output logic [cbe_pkg::XW-1:0]                  out_curve_param,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [2:0]                         cfg_index,
  input  wire logic [cbe_pkg::YW-1:0]             cfg_data
);
  localparam int AW = cbe_pkg::ACC_W;
  localparam int XW = cbe_pkg::XW;
  localparam int NCW = $clog2(NEWTON_STEPS + 2);
  localparam int BCW = $clog2(BISECT_STEPS + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NX   = 4'd1;
  localparam logic [3:0] S_NCHK = 4'd2;
  localparam logic [3:0] S_ND   = 4'd3;
  localparam logic [3:0] S_DCHK = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_BSET = 4'd6;
  localparam logic [3:0] S_BX   = 4'd7;
  localparam logic [3:0] S_BCHK = 4'd8;
  localparam logic [3:0] S_Y    = 4'd9;
  localparam logic [3:0] S_YSAT = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic signed [AW-1:0] ONE_S  = AW'(1) <<< cbe_pkg::FRAC_BITS;
  localparam logic signed [AW-1:0] Y_MIN  = -(AW'(2) <<< cbe_pkg::FRAC_BITS);
  localparam logic signed [AW-1:0] Y_MAX  = AW'(3) <<< cbe_pkg::FRAC_BITS;
  localparam logic signed [AW-1:0] K2     = AW'(2);
  localparam logic signed [AW-1:0] K3     = AW'(3);

  // configuration registers
  logic [XW-1:0]                 c1x_r, c2x_r, tol_r;
  logic signed [cbe_pkg::YW-1:0] c1y_r, c2y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1x_r <= XW'(16384);
      c1y_r <= cbe_pkg::YW'(6554);
      c2x_r <= XW'(16384);
      c2y_r <= cbe_pkg::YW'(65536);
      tol_r <= XW'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbe_pkg::CFG_CTRL1_X:   c1x_r <= cfg_data[XW-1:0];
        cbe_pkg::CFG_CTRL1_Y:   c1y_r <= cfg_data;
        cbe_pkg::CFG_CTRL2_X:   c2x_r <= cfg_data[XW-1:0];
        cbe_pkg::CFG_CTRL2_Y:   c2y_r <= cfg_data;
        cbe_pkg::CFG_TOLERANCE: tol_r <= cfg_data[XW-1:0];
        default: ;
      endcase
    end
  end

  // polynomial coefficients, adds only
  logic signed [AW-1:0] p1x, p2x, p1y, p2y;
  logic signed [AW-1:0] ax, bx, cx, ay, by, cy, ax3, bx2;

  assign p1x = $signed(AW'(c1x_r));
  assign p2x = $signed(AW'(c2x_r));
  assign p1y = AW'(c1y_r);
  assign p2y = AW'(c2y_r);
  assign cx  = K3 * p1x;
  assign bx  = K3 * (p2x - p1x) - cx;
  assign ax  = ONE_S - cx - bx;
  assign cy  = K3 * p1y;
  assign by  = K3 * (p2y - p1y) - cy;
  assign ay  = ONE_S - cy - by;
  assign ax3 = K3 * ax;
  assign bx2 = K2 * bx;

  // sequencer state
  logic [3:0]           st_r, st_nxt;
  logic [1:0]           ph_r, ph_nxt;
  logic [NCW-1:0]       ns_r, ns_nxt;
  logic [BCW-1:0]       bs_r, bs_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [XW-1:0]        t_r, t_nxt;
  logic [XW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [AW-1:0] err_r, err_nxt;
  logic                 dneg_r, dneg_nxt;
  logic signed [cbe_pkg::YW-1:0] y_r, y_nxt;

  cbe_pkg::mac_req_t    mreq;
  logic signed [AW-1:0] acc;
  logic                 dv_start;
  logic [cbe_pkg::NUM_W-1:0] dv_num;
  logic [cbe_pkg::DEN_W-1:0] dv_den;
  logic                 dv_done, dv_run;
  logic [cbe_pkg::NUM_W-1:0] dv_quo;

  cbe_mac u_mac (
    .clk  (clk),
    .req  (mreq),
    .t_in (t_r),
    .acc  (acc)
  );

  cbe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dv_start),
    .num_mag (dv_num),
    .den_mag (dv_den),
    .done    (dv_done),
    .running (dv_run),
    .quo     (dv_quo)
  );

  // helper values
  logic signed [AW-1:0] diff;
  logic [AW-1:0]        diff_abs;
  logic                 in_tol;
  logic [AW-1:0]        err_abs;
  logic [AW-1:0]        d_abs;
  logic signed [cbe_pkg::NUM_W+1:0] tq;
  logic [XW-1:0]        t_clamp;
  logic [XW-1:0]        mid;
  logic [XW-1:0]        x_clamp;

  assign diff     = acc - $signed(AW'(x_r));
  assign diff_abs = diff[AW-1] ? AW'(-diff) : AW'(diff);
  assign in_tol   = diff_abs < AW'(tol_r);
  assign err_abs  = err_r[AW-1] ? AW'(-err_r) : AW'(err_r);
  assign d_abs    = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign dv_num   = {err_abs, cbe_pkg::FRAC_BITS'(0)};
  assign dv_den   = d_abs;
  assign x_clamp  = (in_progress > cbe_pkg::ONE_Q) ? cbe_pkg::ONE_Q : in_progress;

  // newton update t - err*one/d, then clamp to [0, one]
  always_comb begin
    if (err_r[AW-1] ^ dneg_r) begin
      tq = $signed((cbe_pkg::NUM_W+2)'(t_r)) + $signed((cbe_pkg::NUM_W+2)'(dv_quo));
    end else begin
      tq = $signed((cbe_pkg::NUM_W+2)'(t_r)) - $signed((cbe_pkg::NUM_W+2)'(dv_quo));
    end
    if (tq[cbe_pkg::NUM_W+1]) begin
      t_clamp = '0;
    end else if (tq > $signed((cbe_pkg::NUM_W+2)'(cbe_pkg::ONE_Q))) begin
      t_clamp = cbe_pkg::ONE_Q;
    end else begin
      t_clamp = tq[XW-1:0];
    end
  end

  // next bisection bounds and midpoint
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if ($signed(AW'(x_r)) > acc) begin
      lo_nxt = t_r;
    end else begin
      hi_nxt = t_r;
    end
    mid = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  end

  // main sequencer
  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    ns_nxt   = ns_r;
    bs_nxt   = bs_r;
    x_nxt    = x_r;
    t_nxt    = t_r;
    err_nxt  = err_r;
    dneg_nxt = dneg_r;
    y_nxt    = y_r;
    dv_start = 1'b0;
    mreq.en    = 1'b0;
    mreq.mul_a = acc;
    mreq.add   = '0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          x_nxt  = in_progress;
          t_nxt  = x_clamp;
          ns_nxt = '0;
          ph_nxt = '0;
          st_nxt = (NEWTON_STEPS == 0) ? S_BSET : S_NX;
        end
      end
      S_NX, S_BX, S_Y: begin
        mreq.en = 1'b1;
        if (ph_r == 2'd0) begin
          mreq.mul_a = (st_r == S_Y) ? ay : ax;
          mreq.add   = (st_r == S_Y) ? by : bx;
        end else if (ph_r == 2'd1) begin
          mreq.add   = (st_r == S_Y) ? cy : cx;
        end
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt = '0;
          case (st_r)
            S_NX:    st_nxt = S_NCHK;
            S_BX:    st_nxt = S_BCHK;
            default: st_nxt = S_YSAT;
          endcase
        end
      end
      S_NCHK: begin
        err_nxt = diff;
        st_nxt  = in_tol ? S_Y : S_ND;
      end
      S_ND: begin
        mreq.en = 1'b1;
        if (ph_r == 2'd0) begin
          mreq.mul_a = ax3;
          mreq.add   = bx2;
          ph_nxt     = 2'd1;
        end else begin
          mreq.add = cx;
          ph_nxt   = '0;
          st_nxt   = S_DCHK;
        end
      end
      S_DCHK: begin
        dneg_nxt = acc[AW-1];
        if (acc == '0) begin
          st_nxt = S_BSET;
        end else begin
          dv_start = 1'b1;
          st_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          t_nxt  = t_clamp;
          ns_nxt = ns_r + NCW'(1);
          st_nxt = (ns_r + NCW'(1) == NCW'(NEWTON_STEPS)) ? S_BSET : S_NX;
        end
      end
      S_BSET: begin
        ph_nxt = '0;
        bs_nxt = '0;
        if (x_r > cbe_pkg::ONE_Q) begin
          t_nxt  = cbe_pkg::ONE_Q;
          st_nxt = S_Y;
        end else begin
          t_nxt  = x_r;
          st_nxt = S_BX;
        end
      end
      S_BCHK: begin
        if (in_tol) begin
          st_nxt = S_Y;
        end else begin
          t_nxt  = mid;
          bs_nxt = bs_r + BCW'(1);
          st_nxt = ((bs_r + BCW'(1) < BCW'(BISECT_STEPS)) && (lo_nxt < hi_nxt)) ?
                   S_BX : S_Y;
        end
      end
      S_YSAT: begin
        if (acc < Y_MIN) begin
          y_nxt = Y_MIN[cbe_pkg::YW-1:0];
        end else if (acc > Y_MAX) begin
          y_nxt = Y_MAX[cbe_pkg::YW-1:0];
        end else begin
          y_nxt = acc[cbe_pkg::YW-1:0];
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // bisection bounds reset in setup and register on every check
  always_ff @(posedge clk) begin
    if (st_r == S_BSET) begin
      lo_r <= '0;
      hi_r <= cbe_pkg::ONE_Q;
    end else if (st_r == S_BCHK) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ph_r <= '0;
      ns_r <= '0;
      bs_r <= '0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      ns_r <= ns_nxt;
      bs_r <= bs_nxt;
    end
    x_r    <= x_nxt;
    t_r    <= t_nxt;
    err_r  <= err_nxt;
    dneg_r <= dneg_nxt;
    y_r    <= y_nxt;
  end

  // result word
  assign busy            = (st_r != S_IDLE);
  assign out_valid       = (st_r == S_OUT);
  assign out_eased_value = y_r;
  assign out_curve_param = t_r;

  // checks
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !dv_run)
    else $error("divider running while idle");
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_curve_param <= cbe_pkg::ONE_Q))
    else $error("curve parameter out of range");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("word taken but block not busy");
  a_done_div: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (st_r == S_DIV))
    else $error("divider finished outside divide state");
endmodule
`default_nettype wire
